// ===== src/mkey_pkg.sv =====
// Shared types, constants and Morse sign table for the character keyer.
package mkey_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned DotW   = 16;
    localparam int unsigned UnitsW = 3;
    localparam int unsigned DurW   = 19;
    localparam int unsigned PatW   = 6;

    localparam logic [CharW-1:0]  CharSpace  = 8'h20;
    localparam logic [UnitsW-1:0] UnitsDot   = 3'd1;
    localparam logic [UnitsW-1:0] UnitsDash  = 3'd3;
    localparam logic [UnitsW-1:0] UnitsEgap  = 3'd1;
    localparam logic [UnitsW-1:0] UnitsCgap  = 3'd3;
    localparam logic [UnitsW-1:0] UnitsWgap  = 3'd7;
    localparam logic [DotW-1:0]   DotLenRst  = 16'd100;

    typedef enum logic [1:0] {
        SEG_MARK,
        SEG_EGAP,
        SEG_CGAP,
        SEG_SPACE
    } t_seg;

    // Element pattern, first element in the top bit, 1 = dash.
    typedef struct packed {
        logic [2:0]      len;
        logic [PatW-1:0] pat;
    } t_sign;

    typedef struct packed {
        logic capture;
        logic load_seg;
        t_seg seg;
    } t_cmd;

    typedef struct packed {
        logic in_space;
        logic in_len_zero;
        logic more;
    } t_status;

    function automatic t_sign sign_of(input logic [CharW-1:0] c);
        logic [CharW-1:0] u;
        t_sign s;
        u = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            u = c - 8'h20;
        end
        s = '{len: 3'd0, pat: 6'b000000};
        unique case (u)
            8'h41: s = '{3'd2, 6'b010000}; // A
            8'h42: s = '{3'd4, 6'b100000};
            8'h43: s = '{3'd4, 6'b101000};
            8'h44: s = '{3'd3, 6'b100000};
            8'h45: s = '{3'd1, 6'b000000};
            8'h46: s = '{3'd4, 6'b001000};
            8'h47: s = '{3'd3, 6'b110000};
            8'h48: s = '{3'd4, 6'b000000};
            8'h49: s = '{3'd2, 6'b000000};
            8'h4a: s = '{3'd4, 6'b011100};
            8'h4b: s = '{3'd3, 6'b101000};
            8'h4c: s = '{3'd4, 6'b010000};
            8'h4d: s = '{3'd2, 6'b110000};
            8'h4e: s = '{3'd2, 6'b100000};
            8'h4f: s = '{3'd3, 6'b111000};
            8'h50: s = '{3'd4, 6'b011000};
            8'h51: s = '{3'd4, 6'b110100};
            8'h52: s = '{3'd3, 6'b010000};
            8'h53: s = '{3'd3, 6'b000000};
            8'h54: s = '{3'd1, 6'b100000};
            8'h55: s = '{3'd3, 6'b001000};
            8'h56: s = '{3'd4, 6'b000100};
            8'h57: s = '{3'd3, 6'b011000};
            8'h58: s = '{3'd4, 6'b100100};
            8'h59: s = '{3'd4, 6'b101100};
            8'h5a: s = '{3'd4, 6'b110000}; // Z
            8'h30: s = '{3'd5, 6'b111110}; // 0
            8'h31: s = '{3'd5, 6'b011110};
            8'h32: s = '{3'd5, 6'b001110};
            8'h33: s = '{3'd5, 6'b000110};
            8'h34: s = '{3'd5, 6'b000010};
            8'h35: s = '{3'd5, 6'b000000};
            8'h36: s = '{3'd5, 6'b100000};
            8'h37: s = '{3'd5, 6'b110000};
            8'h38: s = '{3'd5, 6'b111000};
            8'h39: s = '{3'd5, 6'b111100}; // 9
            8'h2f: s = '{3'd5, 6'b010100}; // end of message
            8'h2e: s = '{3'd6, 6'b010101}; // .
            8'h2c: s = '{3'd6, 6'b110011}; // ,
            8'h3f: s = '{3'd6, 6'b001100}; // ?
            8'h2d: s = '{3'd6, 6'b100001}; // -
            8'h22: s = '{3'd6, 6'b010010}; // "
            8'h27: s = '{3'd6, 6'b011110}; // '
            8'h28: s = '{3'd5, 6'b101100}; // (
            8'h29: s = '{3'd6, 6'b101101}; // )
            8'h3a: s = '{3'd6, 6'b111000}; // :
            8'h21: s = '{3'd6, 6'b101011}; // !
            default: s = '{len: 3'd0, pat: 6'b000000};
        endcase
        return s;
    endfunction

endpackage

// ===== src/mkey_datapath.sv =====
// Keyer datapath: dot length register, sign shifter and segment output register.
module mkey_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mkey_pkg::DotW-1:0]       i_cfg_data,
    input  logic [mkey_pkg::CharW-1:0]      i_char_code,
    input  mkey_pkg::t_cmd                  i_cmd,
    output mkey_pkg::t_status               o_status,
    output logic                            o_level,
    output logic [mkey_pkg::UnitsW-1:0]     o_units,
    output logic [mkey_pkg::DurW-1:0]       o_duration,
    output logic                            o_last
);

    logic [mkey_pkg::DotW-1:0]   r_dot_length;
    logic [mkey_pkg::PatW-1:0]   r_pat;
    logic [2:0]                  r_left;
    logic                        r_level;
    logic [mkey_pkg::UnitsW-1:0] r_units;
    logic [mkey_pkg::DurW-1:0]   r_duration;
    logic                        r_last;

    mkey_pkg::t_sign             w_sign;
    logic                        n_level;
    logic [mkey_pkg::UnitsW-1:0] n_units;
    logic                        n_last;

    assign w_sign = mkey_pkg::sign_of(i_char_code);

    assign o_status = '{in_space:    (i_char_code == mkey_pkg::CharSpace),
                        in_len_zero: (w_sign.len == 3'd0),
                        more:        (r_left > 3'd1)};

    always_comb begin
        n_level = 1'b0;
        n_units = mkey_pkg::UnitsCgap;
        n_last  = 1'b0;
        unique case (i_cmd.seg)
            mkey_pkg::SEG_MARK: begin
                n_level = 1'b1;
                n_units = r_pat[mkey_pkg::PatW-1] ? mkey_pkg::UnitsDash : mkey_pkg::UnitsDot;
            end
            mkey_pkg::SEG_EGAP: begin
                n_units = mkey_pkg::UnitsEgap;
            end
            mkey_pkg::SEG_CGAP: begin
                n_units = mkey_pkg::UnitsCgap;
                n_last  = 1'b1;
            end
            mkey_pkg::SEG_SPACE: begin
                n_units = mkey_pkg::UnitsWgap;
                n_last  = 1'b1;
            end
            default: begin
                n_units = mkey_pkg::UnitsCgap;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_length <= mkey_pkg::DotLenRst;
        end else if (i_cfg_we) begin
            r_dot_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pat  <= w_sign.pat;
            r_left <= w_sign.len;
        end else if (i_cmd.load_seg && i_cmd.seg == mkey_pkg::SEG_EGAP) begin
            r_pat  <= {r_pat[mkey_pkg::PatW-2:0], 1'b0};
            r_left <= r_left - 3'd1;
        end
        if (i_cmd.load_seg) begin
            r_level    <= n_level;
            r_units    <= n_units;
            r_duration <= mkey_pkg::DurW'(n_units) * mkey_pkg::DurW'(r_dot_length);
            r_last     <= n_last;
        end
    end

    assign o_level    = r_level;
    assign o_units    = r_units;
    assign o_duration = r_duration;
    assign o_last     = r_last;

endmodule

// ===== src/mkey_ctrl.sv =====
// Keyer controller: segment sequencing and output valid.
module mkey_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  mkey_pkg::t_status i_status,
    output mkey_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_EGAP,
        S_CGAP,
        S_SPACE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_free;

    assign w_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '{capture: 1'b0, load_seg: 1'b0, seg: mkey_pkg::SEG_CGAP};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.in_space) begin
                        n_state = S_SPACE;
                    end else if (i_status.in_len_zero) begin
                        n_state = S_CGAP;
                    end else begin
                        n_state = S_MARK;
                    end
                end
            end
            S_MARK: begin
                o_cmd.seg = mkey_pkg::SEG_MARK;
                if (w_free) begin
                    o_cmd.load_seg = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_EGAP;
                end
            end
            S_EGAP: begin
                o_cmd.seg = mkey_pkg::SEG_EGAP;
                if (w_free) begin
                    o_cmd.load_seg = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = i_status.more ? S_MARK : S_CGAP;
                end
            end
            S_CGAP: begin
                o_cmd.seg = mkey_pkg::SEG_CGAP;
                if (w_free) begin
                    o_cmd.load_seg = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SPACE: begin
                o_cmd.seg = mkey_pkg::SEG_SPACE;
                if (w_free) begin
                    o_cmd.load_seg = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("no busy after character transfer");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_seg |-> (!r_out_valid || !i_stall))
        else $error("segment loaded over pending transfer");

    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_seg && (o_cmd.seg == mkey_pkg::SEG_CGAP ||
                            o_cmd.seg == mkey_pkg::SEG_SPACE)) |=> !o_stall)
        else $error("final segment did not end character");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_seg |=> o_valid)
        else $error("loaded segment not presented");

endmodule

// ===== src/morse_character_keyer.sv =====
// Morse character keyer top level: controller and datapath.
// Transfer: the character is captured in idle, then its first segment is loaded once the output is free.
// Throughput: one segment per cycle without output stall; a character gives a mark
// and an element gap per element, then a character gap (a word gap for a space, only a
// character gap for an unknown code). Next character is taken once the last segment is loaded.
// Reset: synchronous active low; dot length returns to 100, output empty.
module morse_character_keyer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mkey_pkg::DotW-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mkey_pkg::CharW-1:0]      i_char_code,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_level,
    output logic [mkey_pkg::UnitsW-1:0]     o_units,
    output logic [mkey_pkg::DurW-1:0]       o_duration,
    output logic                            o_last
);

    mkey_pkg::t_cmd    w_cmd;
    mkey_pkg::t_status w_status;

    mkey_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mkey_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_char_code (i_char_code),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_level     (o_level),
        .o_units     (o_units),
        .o_duration  (o_duration),
        .o_last      (o_last)
    );

endmodule
